[rtl/stereo_peak_limiter_defines.svh]
// Assertion macros used by the stereo_peak_limiter module.
`ifndef STEREO_PEAK_LIMITER_DEFINES_SVH
`define STEREO_PEAK_LIMITER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SPL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spl_pkg.sv]
package spl_pkg;

    // Sample and gain formats
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_WIDTH     = GAIN_FRAC_BITS + 1;
    localparam int COEF_BITS      = 16;
    localparam int THR_WIDTH      = 15;

    // Shared multiplier: signed operands wide enough for a sample, a gain or 1 - coef
    localparam int MUL_BASE  = (SAMPLE_WIDTH > GAIN_WIDTH) ? SAMPLE_WIDTH : GAIN_WIDTH;
    localparam int MUL_WIDTH = ((MUL_BASE > COEF_BITS + 1) ? MUL_BASE : COEF_BITS + 1) + 1;
    localparam int ACC_WIDTH = 2 * MUL_WIDTH;

    // Clip level is 0.99 of full scale, truncated
    localparam int CLIP_LEVEL = (99 * (2 ** (SAMPLE_WIDTH - 1))) / 100;

    localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [COEF_BITS:0]    COEF_ONE   = {1'b1, {COEF_BITS{1'b0}}};

    // Configuration register map
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ATTACK    = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RELEASE   = 2'd3;

    localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = 15'd29205;
    localparam logic [COEF_BITS-1:0] ATTACK_RESET    = 16'd65082;
    localparam logic [COEF_BITS-1:0] RELEASE_RESET   = 16'd65509;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
        logic                           block_end_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
        logic        [GAIN_WIDTH-1:0]   gain_out;
        logic                           block_end_out;
    } t_out_word;

    // Control to the shared multiply-accumulate unit
    typedef struct packed {
        logic go;
        logic clr;
    } t_mac_op;

endpackage

[rtl/spl_div.sv]
// Restoring divider: quotient = (dividend << GAIN_FRAC_BITS) / divisor,
// one quotient bit per cycle. Requires dividend < divisor.
module spl_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [spl_pkg::THR_WIDTH-1:0]           i_dividend,
    input  logic [spl_pkg::SAMPLE_WIDTH-1:0]        i_divisor,
    output logic                                    o_done,
    output logic [spl_pkg::GAIN_FRAC_BITS-1:0]      o_quot
);

    localparam int SW    = spl_pkg::SAMPLE_WIDTH;
    localparam int GF    = spl_pkg::GAIN_FRAC_BITS;
    localparam int CNT_W = $clog2(GF + 1);

    logic [SW-1:0]    r_rem,   n_rem;
    logic [SW-1:0]    r_dvs,   n_dvs;
    logic [GF-1:0]    r_quot,  n_quot;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_done,  n_done;
    logic [SW+1:0]    rem2;
    logic [SW+1:0]    diff;

    // Shift in a zero bit and try to subtract the divisor
    always_comb begin
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        rem2   = {1'b0, r_rem, 1'b0};
        diff   = rem2 - {2'b00, r_dvs};
        if (i_start) begin
            n_rem  = SW'(i_dividend);
            n_dvs  = i_divisor;
            n_quot = '0;
            n_cnt  = CNT_W'(GF);
        end else if (r_cnt != '0) begin
            if (!diff[SW+1]) begin
                n_rem  = diff[SW-1:0];
                n_quot = {r_quot[GF-2:0], 1'b1};
            end else begin
                n_rem  = rem2[SW-1:0];
                n_quot = {r_quot[GF-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/spl_mac.sv]
// Shared multiply-accumulate unit: registered product, then registered sum.
module spl_mac (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  spl_pkg::t_mac_op                          i_op,
    input  logic signed [spl_pkg::MUL_WIDTH-1:0]      i_a,
    input  logic signed [spl_pkg::MUL_WIDTH-1:0]      i_b,
    output logic signed [spl_pkg::ACC_WIDTH-1:0]      o_acc
);

    localparam int AW = spl_pkg::ACC_WIDTH;

    logic signed [AW-1:0] r_prod;
    logic signed [AW-1:0] r_acc, n_acc;
    logic                 r_pv;
    logic                 r_pclr;

    // Add the held product into the accumulator, or restart from it
    always_comb begin
        n_acc = r_acc;
        if (r_pv) begin
            n_acc = r_pclr ? r_prod : r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_pclr <= 1'b0;
        end else begin
            r_pv   <= i_op.go;
            r_pclr <= i_op.clr;
        end
        r_prod <= i_a * i_b;
        r_acc  <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

[rtl/stereo_peak_limiter.sv]
// Stereo peak limiter.
// Input channel: i_in_valid / o_in_stall carry one stereo frame (left, right,
// block end marker) per word. Output channel: o_out_valid / i_out_stall carry
// the limited samples, the gain used for the frame and the copied marker.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 enable, 1 threshold, 2 attack coefficient, 3 release coefficient).
// One frame is worked on at a time; o_in_stall is high from acceptance until
// the result is loaded into the output register. When disabled, a frame
// goes straight to the write state. When enabled and the peak exceeds the
// threshold, the 16-step bit-serial divider first forms the target gain
// (unity otherwise); then the single multiply-accumulate unit takes the
// two envelope terms and the two sample scalings in turn. A new frame can
// be taken as soon as the previous one sits in the output register. If the
// receiver stalls, the output word holds; a following frame is computed and
// then waits for the register. Reset restores the register defaults, unity
// gain and empty channels.
`include "stereo_peak_limiter_defines.svh"

module stereo_peak_limiter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  spl_pkg::t_in_word                     i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output spl_pkg::t_out_word                    o_out_word,
    input  logic                                  i_cfg_we,
    input  logic [spl_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [spl_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);

    localparam int SW    = spl_pkg::SAMPLE_WIDTH;
    localparam int GF    = spl_pkg::GAIN_FRAC_BITS;
    localparam int GW    = spl_pkg::GAIN_WIDTH;
    localparam int CB    = spl_pkg::COEF_BITS;
    localparam int TW    = spl_pkg::THR_WIDTH;
    localparam int MW    = spl_pkg::MUL_WIDTH;
    localparam int AW    = spl_pkg::ACC_WIDTH;
    localparam int ENV_W = AW - CB;
    localparam int SCL_W = AW - GF;

    localparam logic signed [SCL_W-1:0] CLIP_HI = SCL_W'(spl_pkg::CLIP_LEVEL);
    localparam logic signed [SCL_W-1:0] CLIP_LO = -CLIP_HI;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV   = 4'd1;
    localparam logic [3:0] ST_ENV1  = 4'd2;
    localparam logic [3:0] ST_ENV2  = 4'd3;
    localparam logic [3:0] ST_EWAIT = 4'd4;
    localparam logic [3:0] ST_EUPD  = 4'd5;
    localparam logic [3:0] ST_MULL  = 4'd6;
    localparam logic [3:0] ST_MULR  = 4'd7;
    localparam logic [3:0] ST_SCL   = 4'd8;
    localparam logic [3:0] ST_WRITE = 4'd9;

    // Scale by the gain (floor) and clip to the 0.99 level
    function automatic logic signed [SW-1:0] f_scale_clip(
        input logic signed [AW-1:0] p
    );
        logic signed [SCL_W-1:0] sh;
        sh = SCL_W'(p >>> GF);
        if (sh > CLIP_HI) begin
            sh = CLIP_HI;
        end else if (sh < CLIP_LO) begin
            sh = CLIP_LO;
        end
        return sh[SW-1:0];
    endfunction

    // Configuration registers
    logic          r_enable;
    logic [TW-1:0] r_threshold;
    logic [CB-1:0] r_attack;
    logic [CB-1:0] r_release;

    // Sequencer and frame state
    logic [3:0]           r_state,     n_state;
    logic signed [SW-1:0] r_left,      n_left;
    logic signed [SW-1:0] r_right,     n_right;
    logic                 r_be,        n_be;
    logic                 r_lim,       n_lim;
    logic [GW-1:0]        r_target,    n_target;
    logic [GW-1:0]        r_env,       n_env;
    logic                 r_out_valid, n_out_valid;
    spl_pkg::t_out_word   r_out_word,  n_out_word;

    logic                 in_acc;
    logic [SW-1:0]        mag_l;
    logic [SW-1:0]        mag_r;
    logic [SW-1:0]        peak;
    logic                 over;
    logic                 div_start;
    logic                 div_done;
    logic [GF-1:0]        div_quot;
    logic                 attack;
    logic [CB-1:0]        sel_coef;
    logic [CB:0]          sel_coef_inv;
    logic [GW-1:0]        sel_tgt;
    logic [ENV_W-1:0]     env_new;
    logic                 out_free;
    spl_pkg::t_mac_op     mac_op;
    logic signed [MW-1:0] mac_a;
    logic signed [MW-1:0] mac_b;
    logic signed [AW-1:0] mac_acc;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Peak of the two magnitudes; the most negative sample maps to 2^(SW-1)
    assign mag_l = i_in_word.left_in[SW-1]  ? SW'(-i_in_word.left_in)  : i_in_word.left_in;
    assign mag_r = i_in_word.right_in[SW-1] ? SW'(-i_in_word.right_in) : i_in_word.right_in;
    assign peak  = (mag_l > mag_r) ? mag_l : mag_r;
    assign over  = peak > SW'(r_threshold);

    // Attack toward a lower target, otherwise release toward unity
    assign attack       = r_target < r_env;
    assign sel_coef     = attack ? r_attack : r_release;
    assign sel_coef_inv = spl_pkg::COEF_ONE - {1'b0, sel_coef};
    assign sel_tgt      = attack ? r_target : spl_pkg::GAIN_UNITY;
    assign env_new      = mac_acc[AW-1:CB];

    assign div_start = in_acc && r_enable && over;

    spl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_threshold),
        .i_divisor  (peak),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    spl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    // Step the sequencer and feed the shared multiplier
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_right     = r_right;
        n_be        = r_be;
        n_lim       = r_lim;
        n_target    = r_target;
        n_env       = r_env;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        mac_op      = '0;
        mac_a       = '0;
        mac_b       = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_left   = i_in_word.left_in;
                    n_right  = i_in_word.right_in;
                    n_be     = i_in_word.block_end_in;
                    n_lim    = r_enable;
                    n_target = spl_pkg::GAIN_UNITY;
                    if (!r_enable) begin
                        n_state = ST_WRITE;
                    end else if (over) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_ENV1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_target = GW'(div_quot);
                    n_state  = ST_ENV1;
                end
            end
            ST_ENV1: begin
                mac_op  = '{go: 1'b1, clr: 1'b1};
                mac_a   = MW'(sel_coef);
                mac_b   = MW'(r_env);
                n_state = ST_ENV2;
            end
            ST_ENV2: begin
                mac_op  = '{go: 1'b1, clr: 1'b0};
                mac_a   = MW'(sel_coef_inv);
                mac_b   = MW'(sel_tgt);
                n_state = ST_EWAIT;
            end
            ST_EWAIT: begin
                n_state = ST_EUPD;
            end
            ST_EUPD: begin
                if (env_new > ENV_W'(spl_pkg::GAIN_UNITY)) begin
                    n_env = spl_pkg::GAIN_UNITY;
                end else begin
                    n_env = env_new[GW-1:0];
                end
                n_state = ST_MULL;
            end
            ST_MULL: begin
                mac_op  = '{go: 1'b1, clr: 1'b1};
                mac_a   = MW'(r_left);
                mac_b   = MW'(r_env);
                n_state = ST_MULR;
            end
            ST_MULR: begin
                mac_op  = '{go: 1'b1, clr: 1'b1};
                mac_a   = MW'(r_right);
                mac_b   = MW'(r_env);
                n_state = ST_SCL;
            end
            ST_SCL: begin
                n_left  = f_scale_clip(mac_acc);
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    n_out_word.left_out      = r_left;
                    n_out_word.right_out     = r_lim ? f_scale_clip(mac_acc) : r_right;
                    n_out_word.gain_out      = r_env;
                    n_out_word.block_end_out = r_be;
                    n_out_valid              = 1'b1;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_env       <= spl_pkg::GAIN_UNITY;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_threshold <= spl_pkg::THRESHOLD_RESET;
            r_attack    <= spl_pkg::ATTACK_RESET;
            r_release   <= spl_pkg::RELEASE_RESET;
        end else begin
            r_state     <= n_state;
            r_env       <= n_env;
            r_out_valid <= n_out_valid;
            // Take register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spl_pkg::CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                    spl_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[TW-1:0];
                    spl_pkg::CFG_ATTACK:    r_attack    <= i_cfg_data[CB-1:0];
                    spl_pkg::CFG_RELEASE:   r_release   <= i_cfg_data[CB-1:0];
                    default: ;
                endcase
            end
        end
        r_left     <= n_left;
        r_right    <= n_right;
        r_be       <= n_be;
        r_lim      <= n_lim;
        r_target   <= n_target;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `SPL_ASSERT_ALWAYS(a_env_le_unity, i_clk, i_rst_n, r_env <= spl_pkg::GAIN_UNITY, "gain above unity")
    `SPL_ASSERT_NEXT(a_env_hold, i_clk, i_rst_n, r_state != ST_EUPD, $stable(r_env), "gain moved outside update")
    `SPL_ASSERT_NEXT(a_bypass, i_clk, i_rst_n, in_acc && !r_enable, r_state == ST_WRITE, "bypass did not skip to write")
    `SPL_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == ST_WRITE && out_free, o_out_valid && r_state == ST_IDLE, "result word not loaded")

endmodule

[verif/tb_top.sv]
module tb_top;
    import spl_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 4;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 80;
    localparam int HOLD_PHASE       = 2;
    localparam int BYPASS_PHASE     = 4;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TIMEOUT_CYCLES   = 400000;
    localparam int MAX_REPORTS      = 10;

    localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    typedef enum int {LVL_FULL, LVL_LOUD, LVL_EDGE, LVL_QUIET, LVL_EXTREME} t_level;
    typedef enum int {PAT_NONE, PAT_LIGHT, PAT_HEAVY, PAT_ALTERNATE} t_stall_pat;

    // Gain envelope predictor plus the queue of result frames still owed by the block
    class limiter_scoreboard;
        bit                          lim_on;
        bit [THR_WIDTH-1:0]          thr_level;
        bit [COEF_BITS-1:0]          att_coef;
        bit [COEF_BITS-1:0]          rel_coef;
        bit [GAIN_WIDTH-1:0]         env_gain;
        t_out_word                   expected_frames[$];
        int                          errors;
        int                          checked;

        function new();
            lim_on    = 1'b0;
            thr_level = THRESHOLD_RESET;
            att_coef  = ATTACK_RESET;
            rel_coef  = RELEASE_RESET;
            env_gain  = GAIN_UNITY;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                CFG_ENABLE:    lim_on = data[0];
                CFG_THRESHOLD: thr_level = data[THR_WIDTH-1:0];
                CFG_ATTACK:    att_coef = data[COEF_BITS-1:0];
                CFG_RELEASE:   rel_coef = data[COEF_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Floor of sample times gain, then clip to the 0.99 level
        function longint scaled(longint s, longint g);
            longint v;
            v = (s * g) >>> GAIN_FRAC_BITS;
            if (v > CLIP_LEVEL) v = CLIP_LEVEL;
            if (v < -CLIP_LEVEL) v = -CLIP_LEVEL;
            return v;
        endfunction

        // Advance the envelope for one accepted frame and queue its result
        function void take_frame(t_in_word w);
            longint    lft, rgt, rmag, peak, target, env, g, unity, lo, ro;
            t_out_word e;
            lft   = $signed(w.left_in);
            rgt   = $signed(w.right_in);
            unity = longint'(GAIN_UNITY);
            lo    = lft;
            ro    = rgt;
            if (lim_on) begin
                peak = (lft < 0) ? -lft : lft;
                rmag = (rgt < 0) ? -rgt : rgt;
                if (rmag > peak) peak = rmag;
                target = unity;
                if (peak > longint'(thr_level) && peak > 0)
                    target = (longint'(thr_level) << GAIN_FRAC_BITS) / peak;
                env = longint'(env_gain);
                if (target < env) begin
                    g = (longint'(att_coef) * env
                        + (longint'(COEF_ONE) - longint'(att_coef)) * target) >> COEF_BITS;
                end else begin
                    g = (longint'(rel_coef) * env
                        + (longint'(COEF_ONE) - longint'(rel_coef)) * unity) >> COEF_BITS;
                end
                if (g > unity) g = unity;
                env_gain = g[GAIN_WIDTH-1:0];
                lo = scaled(lft, g);
                ro = scaled(rgt, g);
            end
            e.left_out      = lo[SAMPLE_WIDTH-1:0];
            e.right_out     = ro[SAMPLE_WIDTH-1:0];
            e.gain_out      = env_gain;
            e.block_end_out = w.block_end_in;
            expected_frames.push_back(e);
        endfunction

        // Compare one output word with the oldest queued frame
        function void check_frame(t_out_word got);
            t_out_word e;
            if (expected_frames.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output word: L=%0d R=%0d gain=%0d end=%0b",
                             $signed(got.left_out), $signed(got.right_out),
                             got.gain_out, got.block_end_out);
                return;
            end
            e = expected_frames.pop_front();
            checked++;
            if (got.left_out !== e.left_out || got.right_out !== e.right_out ||
                got.gain_out !== e.gain_out || got.block_end_out !== e.block_end_out) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch on frame %0d: expected L=%0d R=%0d gain=%0d end=%0b, got L=%0d R=%0d gain=%0d end=%0b",
                             checked, $signed(e.left_out), $signed(e.right_out),
                             e.gain_out, e.block_end_out, $signed(got.left_out),
                             $signed(got.right_out), got.gain_out, got.block_end_out);
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_word                  i_in_word   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_word                 o_out_word;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data  = '0;

    limiter_scoreboard sb;
    bit                long_hold_req = 1'b0;
    int                holds_done    = 0;
    int                frames_sent   = 0;
    int                settings_used = 1;

    stereo_peak_limiter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Offer one word and hold it until the block takes it
    task automatic send_frame(input t_in_word w);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_frame(w);
        frames_sent++;
    endtask

    task automatic send_pair(input int lft, input int rgt, input bit be);
        t_in_word w;
        w.left_in      = SAMPLE_WIDTH'(lft);
        w.right_in     = SAMPLE_WIDTH'(rgt);
        w.block_end_in = be;
        send_frame(w);
    endtask

    // Drop valid for a number of cycles (at least one)
    task automatic idle_input(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for every queued frame, then let the pipeline settle
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(input t_level lvl, input int thr);
        int mag;
        mag = 0;
        case (lvl)
            LVL_LOUD:  mag = int'($urandom_range(24000, 32768));
            LVL_EDGE: begin
                mag = thr + int'($urandom_range(0, 600)) - 300;
                if (mag < 0) mag = 0;
                if (mag > 32768) mag = 32768;
            end
            LVL_QUIET: mag = int'($urandom_range(0, 2000));
            LVL_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return '0;
                    3: return '1;
                    4: return SAMPLE_WIDTH'(1);
                    default: return MOST_NEG + 1'b1;
                endcase
            end
            default: return SAMPLE_WIDTH'($urandom_range(0, 65535));
        endcase
        if (mag == 32768) return MOST_NEG;
        return ($urandom_range(0, 1) == 1) ? SAMPLE_WIDTH'(-mag) : SAMPLE_WIDTH'(mag);
    endfunction

    function automatic t_level pick_level();
        case ($urandom_range(0, 9))
            0, 1, 2: return LVL_LOUD;
            3, 4:    return LVL_EDGE;
            5, 6:    return LVL_QUIET;
            7, 8:    return LVL_FULL;
            default: return LVL_EXTREME;
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_WIDTH'(32767);
            2, 3:    return CFG_DATA_WIDTH'($urandom_range(0, 32767));
            default: return CFG_DATA_WIDTH'($urandom_range(4000, 32767));
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_WIDTH'($urandom_range(0, 65535));
            default: return CFG_DATA_WIDTH'($urandom_range(60000, 65535));
        endcase
    endfunction

    // Main sequence: reset, directed frames, then randomized register settings
    initial begin : stimulus
        int       ph, n, burst, seg;
        t_level   lvl;
        t_in_word w;
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bypass at reset settings: samples unchanged, gain reported at unity
        send_pair(32767, -32768, 1'b1);
        send_pair(-32768, 32767, 1'b0);
        send_pair(0, 0, 1'b1);
        send_pair(12345, -4321, 1'b0);
        idle_input(1);

        // Limiting at default threshold and coefficients
        wait_drained();
        write_reg(CFG_ENABLE, CFG_DATA_WIDTH'(1));
        settings_used++;
        send_pair(0, 0, 1'b0);
        send_pair(100, -100, 1'b1);
        send_pair(29205, 0, 1'b0);
        send_pair(29206, 0, 1'b0);
        send_pair(-32768, 5, 1'b0);
        send_pair(32767, 32767, 1'b0);
        send_pair(-32768, -32768, 1'b1);
        send_pair(1000, -1000, 1'b0);
        idle_input(1);

        // Zero threshold: any nonzero peak targets zero gain
        wait_drained();
        write_reg(CFG_THRESHOLD, '0);
        settings_used++;
        send_pair(0, 0, 1'b0);
        send_pair(1, 0, 1'b0);
        send_pair(-32768, 32767, 1'b1);
        send_pair(0, -1, 1'b1);
        idle_input(1);

        // Full threshold with instant attack and release
        wait_drained();
        write_reg(CFG_THRESHOLD, CFG_DATA_WIDTH'(32767));
        write_reg(CFG_ATTACK, '0);
        write_reg(CFG_RELEASE, '0);
        settings_used++;
        send_pair(-32768, 0, 1'b0);
        send_pair(32767, -32767, 1'b1);
        send_pair(5, 5, 1'b0);
        idle_input(1);

        // Slowest possible attack and release
        wait_drained();
        write_reg(CFG_ATTACK, '1);
        write_reg(CFG_RELEASE, '1);
        settings_used++;
        send_pair(-32768, -32768, 1'b0);
        send_pair(100, 100, 1'b1);
        idle_input(1);

        // Random phases: loud and quiet stretches drive attack and release
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            write_reg(CFG_ENABLE, (ph == BYPASS_PHASE) ? '0 : CFG_DATA_WIDTH'(1));
            write_reg(CFG_THRESHOLD, pick_threshold());
            write_reg(CFG_ATTACK, pick_coef());
            write_reg(CFG_RELEASE, pick_coef());
            settings_used++;
            if (ph == HOLD_PHASE) long_hold_req = 1'b1;
            burst = $urandom_range(1, 16);
            seg   = 0;
            lvl   = LVL_FULL;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (seg == 0) begin
                    lvl = pick_level();
                    seg = $urandom_range(1, 24);
                end
                w.left_in      = pick_sample(lvl, int'(sb.thr_level));
                w.right_in     = ($urandom_range(0, 3) == 0) ?
                                 pick_sample(pick_level(), int'(sb.thr_level)) :
                                 pick_sample(lvl, int'(sb.thr_level));
                w.block_end_in = ($urandom_range(0, 7) == 0);
                send_frame(w);
                seg--;
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 16);
                    if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
                end
            end
            idle_input(1);
        end

        wait_drained();
        $display("Covered %0d frames over %0d register settings, one %0d-cycle output hold (%0d done).",
                 frames_sent, settings_used, LONG_HOLD_CYCLES, holds_done);
        $display("%0d results compared, %0d mismatches, %0d still outstanding.",
                 sb.checked, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Drive output stall: mixed patterns, plus one long hold on request
    initial begin : output_stall
        t_stall_pat pat;
        int         span;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                repeat (LONG_HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                holds_done++;
            end else begin
                pat  = t_stall_pat'($urandom_range(0, 3));
                span = $urandom_range(10, 80);
                repeat (span) begin
                    @(negedge i_clk);
                    case (pat)
                        PAT_NONE:  i_out_stall <= 1'b0;
                        PAT_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                        PAT_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                        default:   i_out_stall <= ~i_out_stall;
                    endcase
                end
            end
        end
    end

    // Check every word taken from the output channel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_frame(o_out_word);
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Run timed out with %0d results outstanding.", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

endmodule
